### rtl/core/rip_pkg.sv
// Shared types and constants for the radix integer parser.
package rip_pkg;

	localparam int unsigned CHAR_BITS   = 21;
	localparam int unsigned NUMBER_BITS = 64;
	localparam int unsigned RADIX_BITS  = 6;

	localparam logic [CHAR_BITS-1:0]  CH_ZERO    = 21'd48;
	localparam logic [CHAR_BITS-1:0]  CH_UPPER_A = 21'd65;
	localparam logic [CHAR_BITS-1:0]  CH_MINUS   = 21'd45;
	localparam logic [CHAR_BITS-1:0]  CH_R       = 21'd114;
	localparam logic [RADIX_BITS-1:0] DEC_RADIX  = 6'd10;
	localparam logic [RADIX_BITS-1:0] MAX_RADIX  = 6'd36;

	typedef enum logic [4:0] {
		PH_FIRST   = 5'b00001,
		PH_OUTER   = 5'b00010,
		PH_AFTER_R = 5'b00100,
		PH_INNER   = 5'b01000,
		PH_STOPPED = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t                phase;
		logic                  outer_neg;
		logic                  inner_neg;
		logic [RADIX_BITS-1:0] radix;
		logic                  fault;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{
		phase:     PH_FIRST,
		outer_neg: 1'b0,
		inner_neg: 1'b0,
		radix:     DEC_RADIX,
		fault:     1'b0
	};

	typedef struct packed {
		logic [CHAR_BITS-1:0] character;
		logic                 is_last;
	} chr_beat_t;

	typedef struct packed {
		logic signed [NUMBER_BITS-1:0] number;
		logic                          radix_error;
	} num_beat_t;

endpackage

### rtl/core/rip_step.sv
// Per-character next-state and result logic of the radix integer parser.
module rip_step #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  rip_pkg::ctrl_t                         ctrl_q,
	input  logic [VALUE_BITS-1:0]                  acc_q,
	input  logic [rip_pkg::CHAR_BITS-1:0]          character,
	input  logic                                   is_last,
	output rip_pkg::ctrl_t                         ctrl_d,
	output logic [VALUE_BITS-1:0]                  acc_d,
	output rip_pkg::num_beat_t                     result
);

	logic                            is_dec;
	logic                            is_upper;
	logic [rip_pkg::RADIX_BITS-1:0]  digit;
	logic                            digit_ok;
	logic                            outer_side;
	logic [rip_pkg::RADIX_BITS-1:0]  mult;
	logic [VALUE_BITS-1:0]           mac;
	logic [VALUE_BITS-1:0]           value;
	rip_pkg::ctrl_t                  ctrl_n;
	logic [VALUE_BITS-1:0]           acc_n;

	always_comb begin
		is_dec   = (character >= rip_pkg::CH_ZERO) && (character < rip_pkg::CH_ZERO + 21'd10);
		is_upper = (character >= rip_pkg::CH_UPPER_A)
			&& (character < rip_pkg::CH_UPPER_A + 21'd26);
		if (is_dec) begin
			digit = rip_pkg::RADIX_BITS'(character - rip_pkg::CH_ZERO);
		end else begin
			digit = rip_pkg::RADIX_BITS'(character - rip_pkg::CH_UPPER_A) + 6'd10;
		end
		digit_ok   = (is_dec || is_upper) && (digit < ctrl_q.radix);
		outer_side = (ctrl_q.phase == rip_pkg::PH_FIRST) || (ctrl_q.phase == rip_pkg::PH_OUTER);
		mult       = outer_side ? rip_pkg::DEC_RADIX : ctrl_q.radix;
		mac        = VALUE_BITS'(acc_q * VALUE_BITS'(mult)) + VALUE_BITS'(digit);
	end

	always_comb begin
		ctrl_n = ctrl_q;
		acc_n  = acc_q;
		case (ctrl_q.phase)
			rip_pkg::PH_FIRST, rip_pkg::PH_OUTER: begin
				if (ctrl_q.phase == rip_pkg::PH_FIRST && character == rip_pkg::CH_MINUS) begin
					ctrl_n.outer_neg = 1'b1;
					ctrl_n.phase     = rip_pkg::PH_OUTER;
				end else if (is_dec) begin
					acc_n        = mac;
					ctrl_n.phase = rip_pkg::PH_OUTER;
				end else if (character == rip_pkg::CH_R) begin
					// radix taken from the decimal prefix, clamped at 36
					if (acc_q > VALUE_BITS'(rip_pkg::MAX_RADIX)) begin
						ctrl_n.fault = 1'b1;
						ctrl_n.radix = rip_pkg::MAX_RADIX;
					end else begin
						ctrl_n.radix = acc_q[rip_pkg::RADIX_BITS-1:0];
					end
					acc_n        = '0;
					ctrl_n.phase = rip_pkg::PH_AFTER_R;
				end else begin
					ctrl_n.phase = rip_pkg::PH_STOPPED;
				end
			end
			rip_pkg::PH_AFTER_R, rip_pkg::PH_INNER: begin
				if (ctrl_q.phase == rip_pkg::PH_AFTER_R && character == rip_pkg::CH_MINUS) begin
					ctrl_n.inner_neg = 1'b1;
					ctrl_n.phase     = rip_pkg::PH_INNER;
				end else if (digit_ok) begin
					acc_n        = mac;
					ctrl_n.phase = rip_pkg::PH_INNER;
				end else begin
					ctrl_n.phase = rip_pkg::PH_STOPPED;
				end
			end
			default: begin
				ctrl_n = ctrl_q;
			end
		endcase
	end

	always_comb begin
		value = (ctrl_n.outer_neg != ctrl_n.inner_neg) ? (~acc_n + VALUE_BITS'(1)) : acc_n;
		result.number      = rip_pkg::NUMBER_BITS'($signed(value));
		result.radix_error = ctrl_n.fault;
		if (is_last) begin
			ctrl_d = rip_pkg::CTRL_RESET;
			acc_d  = '0;
		end else begin
			ctrl_d = ctrl_n;
			acc_d  = acc_n;
		end
	end

endmodule

### rtl/core/radix_integer_parser_unit.sv
// Top level of the radix integer parser: input stage, parse state and result register.
// A character beat is registered in beat_s1 and parsed from there; the result beat for a
// string is registered in out_q once its last character is parsed, and drives num.
// Throughput: one character per cycle; the parse step (one multiply-add) sets the cycle.
// chr_ready drops only while a last-character beat waits on a stalled result register.
// Reset: arst_n clears valids and parse state; parsing restarts in PH_FIRST, radix ten.
module radix_integer_parser_unit #(
	parameter int unsigned VALUE_BITS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               chr_valid,
	output logic               chr_ready,
	input  rip_pkg::chr_beat_t chr,
	output logic               num_valid,
	input  logic               num_ready,
	output rip_pkg::num_beat_t num
);

	logic                  valid_s1;
	rip_pkg::chr_beat_t    beat_s1;
	rip_pkg::ctrl_t        ctrl_q;
	logic [VALUE_BITS-1:0] acc_q;
	rip_pkg::ctrl_t        ctrl_d;
	logic [VALUE_BITS-1:0] acc_d;
	rip_pkg::num_beat_t    result;
	logic                  out_valid_q;
	rip_pkg::num_beat_t    out_q;
	logic                  advance;

	assign advance   = valid_s1 && (!beat_s1.is_last || !out_valid_q || num_ready);
	assign chr_ready = !valid_s1 || advance;
	assign num_valid = out_valid_q;
	assign num       = out_q;

	rip_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.ctrl_q   (ctrl_q),
		.acc_q    (acc_q),
		.character(beat_s1.character),
		.is_last  (beat_s1.is_last),
		.ctrl_d   (ctrl_d),
		.acc_d    (acc_d),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr_ready) begin
			valid_s1 <= chr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr_ready && chr_valid) begin
			beat_s1 <= chr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= rip_pkg::CTRL_RESET;
			acc_q  <= '0;
		end else if (advance) begin
			ctrl_q <= ctrl_d;
			acc_q  <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && beat_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (num_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.is_last) begin
			out_q <= result;
		end
	end

	// string end returns parse state to its start
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.is_last |=> ctrl_q == rip_pkg::CTRL_RESET && acc_q == '0)
		else $error("parse state not cleared after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.is_last |=> out_valid_q)
		else $error("result beat missing after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		!chr_ready |-> valid_s1 && beat_s1.is_last && out_valid_q && !num_ready)
		else $error("input stalled without a blocked result");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.radix <= rip_pkg::MAX_RADIX)
		else $error("radix above limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.fault |-> ctrl_q.phase != rip_pkg::PH_FIRST && ctrl_q.phase != rip_pkg::PH_OUTER)
		else $error("radix fault set before radix marker");

endmodule

### tb/sv/radix_integer_parser_unit_tb.sv
// Self-checking testbench for radix_integer_parser_unit: directed and random strings, prediction, scoreboard.
module radix_integer_parser_unit_tb;

	localparam int unsigned CHARS_PER_PHASE = 440;
	localparam int unsigned NUM_PHASES      = 4;
	localparam int unsigned STALL_LIMIT     = 4000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam logic [rip_pkg::CHAR_BITS-1:0] CH_MAX_CODE = 21'd1114111;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               chr_valid = 1'b0;
	logic               chr_ready;
	rip_pkg::chr_beat_t chr = '0;
	logic               num_valid;
	logic               num_ready = 1'b0;
	rip_pkg::num_beat_t num;

	radix_integer_parser_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready),
		.chr       (chr),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num       (num)
	);

	rip_pkg::chr_beat_t            pending_chars[$];
	rip_pkg::num_beat_t            expected_numbers[$];
	logic [rip_pkg::CHAR_BITS-1:0] text_buf[$];

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned chars_queued = 0;
	int unsigned strings_queued = 0;
	int unsigned results_checked = 0;
	int unsigned faults_seen = 0;
	int unsigned stall_cycles = 0;
	logic        chr_fire = 1'b0;

	// parser state mirror
	rip_pkg::phase_t                 parse_phase = rip_pkg::PH_FIRST;
	logic [rip_pkg::NUMBER_BITS-1:0] parse_acc = '0;
	logic                            outer_neg = 1'b0;
	logic                            inner_neg = 1'b0;
	logic [rip_pkg::RADIX_BITS-1:0]  parse_radix = rip_pkg::DEC_RADIX;
	logic                            parse_fault = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR: %s", msg);
		mismatches++;
	endtask

	task automatic clear_parser();
		parse_phase = rip_pkg::PH_FIRST;
		parse_acc   = '0;
		outer_neg   = 1'b0;
		inner_neg   = 1'b0;
		parse_radix = rip_pkg::DEC_RADIX;
		parse_fault = 1'b0;
	endtask

	function automatic int unsigned digit_of(input logic [rip_pkg::CHAR_BITS-1:0] c);
		if (c >= rip_pkg::CH_ZERO && c < rip_pkg::CH_ZERO + 21'd10)
			return 32'(c - rip_pkg::CH_ZERO);
		if (c >= rip_pkg::CH_UPPER_A && c < rip_pkg::CH_UPPER_A + 21'd26)
			return 32'(c - rip_pkg::CH_UPPER_A) + 32'd10;
		return 32'd99;
	endfunction

	task automatic outer_step(input logic [rip_pkg::CHAR_BITS-1:0] c);
		if (c >= rip_pkg::CH_ZERO && c < rip_pkg::CH_ZERO + 21'd10) begin
			parse_acc   = parse_acc * 64'd10 + 64'(c - rip_pkg::CH_ZERO);
			parse_phase = rip_pkg::PH_OUTER;
		end else if (c == rip_pkg::CH_R) begin
			if (parse_acc > 64'(rip_pkg::MAX_RADIX)) begin
				parse_fault = 1'b1;
				parse_radix = rip_pkg::MAX_RADIX;
			end else begin
				parse_radix = parse_acc[rip_pkg::RADIX_BITS-1:0];
			end
			parse_acc   = '0;
			parse_phase = rip_pkg::PH_AFTER_R;
		end else begin
			parse_phase = rip_pkg::PH_STOPPED;
		end
	endtask

	task automatic inner_step(input logic [rip_pkg::CHAR_BITS-1:0] c);
		int unsigned d;
		d = digit_of(c);
		if (d < 32'(parse_radix)) begin
			parse_acc   = parse_acc * 64'(parse_radix) + 64'(d);
			parse_phase = rip_pkg::PH_INNER;
		end else begin
			parse_phase = rip_pkg::PH_STOPPED;
		end
	endtask

	task automatic parse_beat(input rip_pkg::chr_beat_t b);
		rip_pkg::num_beat_t              res;
		logic [rip_pkg::NUMBER_BITS-1:0] v;
		case (parse_phase)
			rip_pkg::PH_FIRST: begin
				if (b.character == rip_pkg::CH_MINUS) begin
					outer_neg   = 1'b1;
					parse_phase = rip_pkg::PH_OUTER;
				end else begin
					outer_step(b.character);
				end
			end
			rip_pkg::PH_OUTER: outer_step(b.character);
			rip_pkg::PH_AFTER_R: begin
				if (b.character == rip_pkg::CH_MINUS) begin
					inner_neg   = 1'b1;
					parse_phase = rip_pkg::PH_INNER;
				end else begin
					inner_step(b.character);
				end
			end
			rip_pkg::PH_INNER: inner_step(b.character);
			default: ;
		endcase
		if (b.is_last) begin
			v = parse_acc;
			if (outer_neg != inner_neg)
				v = -v;
			res.number      = v;
			res.radix_error = parse_fault;
			expected_numbers.push_back(res);
			if (parse_fault)
				faults_seen++;
			clear_parser();
		end
	endtask

	task automatic check_result(input rip_pkg::num_beat_t got);
		rip_pkg::num_beat_t want;
		if (expected_numbers.size() == 0) begin
			report_mismatch($sformatf("result beat %h with nothing expected", got));
		end else begin
			want = expected_numbers.pop_front();
			if (got.number !== want.number)
				report_mismatch($sformatf("number %0d, expected %0d", got.number, want.number));
			if (got.radix_error !== want.radix_error)
				report_mismatch($sformatf("radix_error %b, expected %b",
					got.radix_error, want.radix_error));
			results_checked++;
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			chr_valid <= 1'b0;
		end else if (!chr_valid || chr_fire) begin
			if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				chr_valid <= 1'b1;
				chr       <= pending_chars.pop_front();
			end else begin
				chr_valid <= 1'b0;
			end
		end
		num_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			chr_fire <= 1'b0;
		end else begin
			chr_fire <= chr_valid && chr_ready;
			if (chr_valid && chr_ready)
				parse_beat(chr);
			if (num_valid && num_ready)
				check_result(num);
		end
	end

	always @(posedge clk) begin
		if ((chr_valid && chr_ready) || (num_valid && num_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("radix_integer_parser_unit test failed");
			$finish;
		end
	end

	task automatic put_char(input logic [rip_pkg::CHAR_BITS-1:0] c);
		text_buf.push_back(c);
	endtask

	task automatic put_digit(input int unsigned d);
		if (d < 10)
			put_char(rip_pkg::CH_ZERO + 21'(d));
		else
			put_char(rip_pkg::CH_UPPER_A + 21'(d - 10));
	endtask

	task automatic put_text(input string t);
		for (int i = 0; i < t.len(); i++)
			put_char({13'b0, t[i]});
	endtask

	task automatic end_string();
		rip_pkg::chr_beat_t b;
		foreach (text_buf[i]) begin
			b.character = text_buf[i];
			b.is_last   = (i == text_buf.size() - 1);
			pending_chars.push_back(b);
		end
		chars_queued += text_buf.size();
		strings_queued++;
		text_buf.delete();
	endtask

	function automatic logic [rip_pkg::CHAR_BITS-1:0] noise_char();
		logic [rip_pkg::CHAR_BITS-1:0] c;
		case ($urandom_range(6))
			0: c = rip_pkg::CH_MINUS;
			1: c = rip_pkg::CH_R;
			2: c = rip_pkg::CH_ZERO + 21'($urandom_range(9));
			3: c = rip_pkg::CH_UPPER_A + 21'($urandom_range(25));
			4: c = 21'd97 + 21'($urandom_range(25));
			5: c = $urandom_range(1) ? 21'd58 + 21'($urandom_range(6))
				: ($urandom_range(1) ? 21'd47 : 21'd91);
			default: c = 21'($urandom_range(CH_MAX_CODE));
		endcase
		return c;
	endfunction

	task automatic gen_random_string();
		int unsigned radix;
		int unsigned eff;
		int unsigned n;
		string       radix_text;
		if ($urandom_range(99) < 75) begin
			if ($urandom_range(2) == 0)
				put_char(rip_pkg::CH_MINUS);
			if ($urandom_range(2) == 0) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(19, 24) : $urandom_range(1, 6);
				repeat (n) put_digit($urandom_range(9));
			end else begin
				radix = ($urandom_range(9) == 0) ? $urandom_range(37, 99) : $urandom_range(0, 36);
				if (!(radix == 0 && $urandom_range(1) == 0)) begin
					radix_text = $sformatf("%0d", radix);
					put_text(radix_text);
				end
				put_char(rip_pkg::CH_R);
				if ($urandom_range(2) == 0)
					put_char(rip_pkg::CH_MINUS);
				eff = (radix > 36) ? 36 : radix;
				n = ($urandom_range(9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
				repeat (n) begin
					if (eff == 0 || $urandom_range(11) == 0)
						put_digit($urandom_range(35));
					else
						put_digit($urandom_range(eff - 1));
				end
			end
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) put_char(noise_char());
		end else begin
			repeat ($urandom_range(1, 6)) put_char(noise_char());
		end
		if (text_buf.size() == 0)
			put_char(noise_char());
		end_string();
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_chars.size() != 0 || chr_valid || expected_numbers.size() != 0);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
				default: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
			endcase
			if (p == 0) begin
				put_text("-2r-1"); end_string();
				put_text("40rZ");  end_string();
				put_text("r0");    end_string();
				put_text("1r0");   end_string();
				put_text("-");     end_string();
				put_text("a");     end_string();
				put_text("9:");    end_string();
				put_text("7-");    end_string();
				put_text("3r");    end_string();
				put_char(CH_MAX_CODE); end_string();
			end
			while (chars_queued < (p + 1) * CHARS_PER_PHASE)
				gen_random_string();
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d characters in %0d strings over %0d idle/stall mixes",
			chars_queued, strings_queued, NUM_PHASES);
		$display("checked %0d numbers, %0d with radix above 36, %0d mismatches",
			results_checked, faults_seen, mismatches);
		if (mismatches == 0)
			$display("radix_integer_parser_unit test passed");
		else
			$display("radix_integer_parser_unit test failed");
		$finish;
	end

endmodule
